@@ sv/pbsa_pkg.sv @@
// shared types, codes and constants for the pci bar sizing and assignment block
// no dependencies; imported by every module of the block

package pbsa_pkg;

	// opcode of an input item
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_ASSIGN  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_NOSIZE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_IO_START       = 2'd0;
	localparam logic [1:0] REG_MEM32_START    = 2'd1;
	localparam logic [1:0] REG_MEM64_START    = 2'd2;
	localparam logic [1:0] REG_IO_SPACE_LIMIT = 2'd3;

	// bar encoding
	localparam logic [31:0] IO_ADDR_MASK  = 32'hFFFF_FFFC;
	localparam logic [31:0] MEM_ADDR_MASK = 32'hFFFF_FFF0;
	localparam logic [1:0]  MEM_TYPE_64   = 2'b10;

	localparam logic [31:0] IO_SPACE_LIMIT_RESET = 32'h0000_FFFF;
	localparam logic [63:0] ALL_ONES             = ~64'd0;

	// which running base an item draws from
	typedef enum logic [1:0] {
		SEL_IO,
		SEL_MEM32,
		SEL_MEM64
	} base_sel_t;

	// configuration as seen by the datapath; starts are held minus one
	typedef struct packed {
		logic [63:0] io_start_m1;
		logic [63:0] mem32_start_m1;
		logic [63:0] mem64_start_m1;
		logic [31:0] io_space_mask;
	} cfg_t;

	// decoded item held in the input register
	typedef struct packed {
		logic        restart;
		logic [1:0]  status;
		logic        is_io;
		logic        is_prefetch;
		logic        is_wide;
		base_sel_t   sel;
		logic [63:0] low_mask;
	} bar_dec_t;

endpackage

@@ sv/pbsa_cfg.sv @@
// configuration registers: start addresses and i/o decode mask
// depends on pbsa_pkg

module pbsa_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [63:0]    cfg_data,
	output pbsa_pkg::cfg_t cfg
);
	import pbsa_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg         = cfg_q;

	// register writes; starts are stored minus one for the allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.io_start_m1    <= ALL_ONES;
			cfg_q.mem32_start_m1 <= ALL_ONES;
			cfg_q.mem64_start_m1 <= ALL_ONES;
			cfg_q.io_space_mask  <= IO_SPACE_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IO_START:       cfg_q.io_start_m1    <= {32'd0, cfg_data[31:0]} - 64'd1;
				REG_MEM32_START:    cfg_q.mem32_start_m1 <= {32'd0, cfg_data[31:0]} - 64'd1;
				REG_MEM64_START:    cfg_q.mem64_start_m1 <= cfg_data - 64'd1;
				REG_IO_SPACE_LIMIT: cfg_q.io_space_mask  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

endmodule

@@ sv/pbsa_decode.sv @@
// bar type decode and size mask extraction for one item
// depends on pbsa_pkg

module pbsa_decode (
	input  logic               opcode,
	input  logic [31:0]        readback_low,
	input  logic [31:0]        readback_high,
	input  logic [31:0]        io_space_mask,
	output pbsa_pkg::bar_dec_t dec
);
	import pbsa_pkg::*;

	logic        io;
	logic        pf;
	logic        wide;
	logic [63:0] bits;
	logic [63:0] mask;
	logic [63:0] avail;

	// type and address bits
	always_comb begin
		io   = readback_low[0];
		pf   = 1'b0;
		wide = 1'b0;
		if (io) begin
			bits = {32'd0, readback_low & IO_ADDR_MASK};
			mask = {32'd0, IO_ADDR_MASK & io_space_mask};
		end else begin
			pf   = readback_low[3];
			wide = (readback_low[2:1] == MEM_TYPE_64);
			bits = {(wide ? readback_high : 32'd0), readback_low & MEM_ADDR_MASK};
			mask = {(wide ? 32'hFFFF_FFFF : 32'd0), MEM_ADDR_MASK};
		end
		avail = bits & mask;
	end

	// status, flags and mask of the bits below the lowest decoded bit
	always_comb begin
		dec.restart     = (opcode == OP_RESTART);
		dec.status      = ST_OK;
		dec.is_io       = 1'b0;
		dec.is_prefetch = 1'b0;
		dec.is_wide     = 1'b0;
		dec.sel         = io ? SEL_IO : (wide ? SEL_MEM64 : SEL_MEM32);
		dec.low_mask    = (avail - 64'd1) & ~avail;
		if (!dec.restart) begin
			if (bits == 64'd0) begin
				dec.status = ST_EMPTY;
			end else begin
				dec.is_io       = io;
				dec.is_prefetch = pf;
				dec.is_wide     = wide;
				if (avail == 64'd0) begin
					dec.status = ST_NOSIZE;
				end
			end
		end
	end

endmodule

@@ sv/pbsa_alloc.sv @@
// running bases, align and advance, and the result register
// depends on pbsa_pkg

module pbsa_alloc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  pbsa_pkg::bar_dec_t dec_s1,
	input  pbsa_pkg::cfg_t     cfg,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               is_io,
	output logic               is_prefetch,
	output logic               is_wide,
	output logic [63:0]        region_start,
	output logic [63:0]        region_end
);
	import pbsa_pkg::*;

	// bases hold the last address handed out, so one add gives the next region
	logic [63:0] io_last_q;
	logic [63:0] mem32_last_q;
	logic [63:0] mem64_last_q;
	logic [63:0] base;
	logic [63:0] sum;
	logic [63:0] start;
	logic [63:0] fin;
	logic        grant;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        is_io_q;
	logic        is_prefetch_q;
	logic        is_wide_q;
	logic [63:0] start_q;
	logic [63:0] end_q;

	assign adv = s1_valid && (!out_valid_q || !out_stall);

	// align the selected base and find the region end
	always_comb begin
		case (dec_s1.sel)
			SEL_IO:    base = io_last_q;
			SEL_MEM32: base = mem32_last_q;
			SEL_MEM64: base = mem64_last_q;
			default:   base = mem32_last_q;
		endcase
		sum   = base + dec_s1.low_mask + 64'd1;
		start = sum & ~dec_s1.low_mask;
		fin   = start | dec_s1.low_mask;
		grant = !dec_s1.restart && (dec_s1.status == ST_OK);
	end

	// running bases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_last_q    <= ALL_ONES;
			mem32_last_q <= ALL_ONES;
			mem64_last_q <= ALL_ONES;
		end else if (adv) begin
			if (dec_s1.restart) begin
				io_last_q    <= cfg.io_start_m1;
				mem32_last_q <= cfg.mem32_start_m1;
				mem64_last_q <= cfg.mem64_start_m1;
			end else if (grant) begin
				case (dec_s1.sel)
					SEL_IO:    io_last_q    <= fin;
					SEL_MEM32: mem32_last_q <= fin;
					SEL_MEM64: mem64_last_q <= fin;
					default: ;
				endcase
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv || (out_valid_q && out_stall);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q      <= dec_s1.status;
			is_io_q       <= dec_s1.is_io;
			is_prefetch_q <= dec_s1.is_prefetch;
			is_wide_q     <= dec_s1.is_wide;
			start_q       <= grant ? start : 64'd0;
			end_q         <= grant ? fin : 64'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign is_io        = is_io_q;
	assign is_prefetch  = is_prefetch_q;
	assign is_wide      = is_wide_q;
	assign region_start = start_q;
	assign region_end   = end_q;

	// region is a power-of-two block aligned to its own size
	a_region_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(end_q - start_q + 64'd1))
		else $error("region size not a power of two");

	a_region_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((start_q & (end_q - start_q)) == 64'd0))
		else $error("region start not aligned");

	// unassigned results carry no region
	a_no_region: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_OK)) |-> (start_q == 64'd0 && end_q == 64'd0))
		else $error("region reported for unassigned bar");

	// restart reloads every base; this check covers the i/o and 64-bit memory bases
	a_restart_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dec_s1.restart) |=> (io_last_q == $past(cfg.io_start_m1)
			&& mem64_last_q == $past(cfg.mem64_start_m1)))
		else $error("restart did not reload bases");

	// a held result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !adv)
		else $error("stalled result overwritten");

endmodule

@@ sv/pci_bar_size_and_assign.sv @@
// pci bar sizing and bump allocation: decodes a bar readback and assigns an aligned region
// stages: two register stages, the decoded item register and then the result register
// throughput: one item per cycle while out_stall is low; the base align-add and advance share one 64-bit adder
// the running bases are read and written in the same stage, so items follow back to back
// reset: start registers hold all ones (a start of zero), io decode mask 0xffff, bases to the start values
// depends on pbsa_pkg, pbsa_cfg, pbsa_decode, pbsa_alloc

module pci_bar_size_and_assign (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] readback_low,
	input  logic [31:0] readback_high,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        is_io,
	output logic        is_prefetch,
	output logic        is_wide,
	output logic [63:0] region_start,
	output logic [63:0] region_end
);
	import pbsa_pkg::*;

	cfg_t     cfg;
	bar_dec_t dec;
	bar_dec_t dec_s1;
	logic     s1_valid;
	logic     adv;
	logic     in_take;

	pbsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pbsa_decode u_decode (
		.opcode        (opcode),
		.readback_low  (readback_low),
		.readback_high (readback_high),
		.io_space_mask (cfg.io_space_mask),
		.dec           (dec)
	);

	// input register handshake
	assign in_stall = s1_valid && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= in_take || (s1_valid && !adv);
		end
	end

	// decoded item register
	always_ff @(posedge clk) begin
		if (in_take) begin
			dec_s1 <= dec;
		end
	end

	pbsa_alloc u_alloc (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.dec_s1       (dec_s1),
		.cfg          (cfg),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.is_io        (is_io),
		.is_prefetch  (is_prefetch),
		.is_wide      (is_wide),
		.region_start (region_start),
		.region_end   (region_end)
	);

endmodule
